>>> hdl/mfcp_pkg.sv
`default_nettype none

package mfcp_pkg;

  // Frame geometry and sizing.
  localparam int MAX_FRAME = 256;
  localparam int CNT_W     = $clog2(MAX_FRAME + 1);
  localparam int HDR_LEN   = 36;

  // CRC lanes: one lane per network init value.
  localparam int NUM_INITS = 15;
  localparam int TABLE_LEN = 15;
  localparam int NUM_LANES = (NUM_INITS < TABLE_LEN) ? NUM_INITS : TABLE_LEN;
  localparam int IDX_W     = 4;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Frame codes.
  localparam logic [7:0] TYPE_CODE = 8'h2A;
  localparam logic [7:0] SUB_SHORT = 8'hD2;
  localparam logic [7:0] SUB_LONG  = 8'h55;
  localparam logic [7:0] SUB_DEST4 = 8'hD5;
  localparam logic [7:0] LEN_FULL  = 8'h47;

  // Network init values, in match priority order.
  localparam logic [15:0] NET_INIT [TABLE_LEN] = '{
    16'hE623, 16'h5FD6, 16'hD553, 16'h45F8, 16'h62C1, 16'h23D1, 16'h2C22, 16'h142A,
    16'h47F7, 16'h22C6, 16'h8819, 16'h4E2D, 16'h1D65, 16'hB9A9, 16'hD1FF
  };

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_OTHER_TYPE   = 3'd1,
    ST_SHORT_FRAME  = 3'd2,
    ST_LENGTH_SHORT = 3'd3,
    ST_CRC_FAIL     = 3'd4
  } status_t;

  // Control from the frame tracker to the CRC lane bank.
  typedef struct packed {
    logic accept;
    logic restart;
    logic update;
  } lane_ctrl_t;

  // Lane bank answer: first lane whose CRC equals the received CRC.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
  } lane_match_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  subtype;
    logic [3:0]  net_index;
    logic [15:0] network_id;
    logic        proto_v5;
    logic [31:0] source_id;
    logic [47:0] source_wan;
    logic [47:0] dest_address;
    logic [31:0] uptime;
    logic [31:0] timestamp;
    logic [4:0]  present_mask;
  } result_t;

  // One byte through an MSB-first CRC-16, no reflection.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] v;
    v = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      v = v[15] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    return v;
  endfunction

  function automatic logic [15:0] net_init_value(input logic [IDX_W-1:0] idx);
    logic [15:0] v;
    v = '0;
    for (int i = 0; i < TABLE_LEN; i++) begin
      if (idx == IDX_W'(i)) begin
        v = NET_INIT[i];
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hdl/mfcp_frame_if.sv
`default_nettype none

// Word channel carrying decoded frame bytes.
interface mfcp_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;
  logic       version_v5;

  modport source(output valid, data_byte, first_byte, last_byte, version_v5, input ready);
  modport sink(input valid, data_byte, first_byte, last_byte, version_v5, output ready);
endinterface

// Word channel carrying one parse result per frame.
interface mfcp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  subtype;
  logic [3:0]  net_index;
  logic [15:0] network_id;
  logic        proto_v5;
  logic [31:0] source_id;
  logic [47:0] source_wan;
  logic [47:0] dest_address;
  logic [31:0] uptime;
  logic [31:0] timestamp;
  logic [4:0]  present_mask;

  modport source(output valid, status, subtype, net_index, network_id, proto_v5, source_id,
                 source_wan, dest_address, uptime, timestamp, present_mask, input ready);
  modport sink(input valid, status, subtype, net_index, network_id, proto_v5, source_id,
               source_wan, dest_address, uptime, timestamp, present_mask, output ready);
endinterface

`default_nettype wire

>>> hdl/mfcp_crc_lanes.sv
`default_nettype none

module mfcp_crc_lanes (
  input  wire                  clk,
  input  wire                  rst,
  input  mfcp_pkg::lane_ctrl_t  ctrl,
  input  wire  [7:0]           data,
  input  wire  [15:0]          crc_rx,
  output mfcp_pkg::lane_match_t match
);

  logic [15:0] lanes      [mfcp_pkg::NUM_LANES];
  logic [15:0] lanes_next [mfcp_pkg::NUM_LANES];

  // Each lane restarts from its init value and absorbs data bytes of the body.
  always_comb begin
    for (int i = 0; i < mfcp_pkg::NUM_LANES; i++) begin
      lanes_next[i] = ctrl.restart ? mfcp_pkg::NET_INIT[i] : lanes[i];
      if (ctrl.update) begin
        lanes_next[i] = mfcp_pkg::crc_byte(lanes_next[i], data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mfcp_pkg::NUM_LANES; i++) begin
        lanes[i] <= mfcp_pkg::NET_INIT[i];
      end
    end else if (ctrl.accept) begin
      for (int i = 0; i < mfcp_pkg::NUM_LANES; i++) begin
        lanes[i] <= lanes_next[i];
      end
    end
  end

  // Priority match: the lowest lane that equals the received CRC wins.
  always_comb begin
    match.found = 1'b0;
    match.index = '0;
    for (int i = mfcp_pkg::NUM_LANES - 1; i >= 0; i--) begin
      if (lanes_next[i] == crc_rx) begin
        match.found = 1'b1;
        match.index = mfcp_pkg::IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/meter_frame_crc_parser_unit.sv
`default_nettype none

// Meter frame parser: takes one decoded frame byte per cycle, marked first and last,
// checks the type byte, the length and the CRC-16 against fifteen network init values
// in parallel, and on the last byte of a frame delivers one result word with the status,
// the matching network and the address, uptime and clock fields of the frame. A byte is
// taken in every cycle while the result register is free or being emptied; the result
// of a frame appears in the cycle after its last byte. The cost per byte is one pass of
// the byte-wide CRC network of each lane followed by the lane compare and field selection.
module meter_frame_crc_parser_unit (
  input wire               clk,
  input wire               rst,
  mfcp_frame_if.sink       frame,
  mfcp_result_if.source    result
);

  // Frame tracking state.
  logic [mfcp_pkg::CNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]      frame_length, frame_length_next;
  logic             short_header, short_header_next;
  logic [7:0]       header_bytes [mfcp_pkg::HDR_LEN];
  logic [7:0]       header_bytes_next [mfcp_pkg::HDR_LEN];
  logic [15:0]      received_crc, received_crc_next;
  logic             version_flag, version_flag_next;

  logic               res_valid;
  mfcp_pkg::result_t  res, res_next;

  logic                       accept;
  logic [mfcp_pkg::CNT_W-1:0] pos;
  logic                       in_range;
  logic [mfcp_pkg::CNT_W-1:0] body_start;
  logic [16:0]                body_offset;
  logic [16:0]                len_ext;
  logic                       in_body;
  logic [16:0]                need;
  logic                       up_nonzero;
  mfcp_pkg::lane_ctrl_t       lane_ctrl;
  mfcp_pkg::lane_match_t      lane_match;

  // The result register parts the two sides: a byte is taken whenever it is free.
  assign frame.ready = !res_valid || result.ready;
  assign accept      = frame.valid && frame.ready;

  // Next frame state from the current byte, with a frame start restoring reset values and taking the version flag.
  always_comb begin
    pos               = frame.first_byte ? '0 : byte_count;
    frame_length_next = frame.first_byte ? '0 : frame_length;
    short_header_next = frame.first_byte ? 1'b0 : short_header;
    received_crc_next = frame.first_byte ? '0 : received_crc;
    version_flag_next = frame.first_byte ? frame.version_v5 : version_flag;
    in_range          = pos < mfcp_pkg::CNT_W'(mfcp_pkg::MAX_FRAME);

    for (int i = 0; i < mfcp_pkg::HDR_LEN; i++) begin
      header_bytes_next[i] = frame.first_byte ? 8'h00 : header_bytes[i];
      if (in_range && pos == mfcp_pkg::CNT_W'(i)) begin
        header_bytes_next[i] = frame.data_byte;
      end
    end

    if (in_range && pos == mfcp_pkg::CNT_W'(1)) begin
      short_header_next = (frame.data_byte == mfcp_pkg::SUB_SHORT);
    end
    if (in_range && pos == mfcp_pkg::CNT_W'(2)) begin
      frame_length_next = short_header_next ? {8'h00, frame.data_byte}
                                            : {frame.data_byte, 8'h00};
    end
    if (in_range && pos == mfcp_pkg::CNT_W'(3) && !short_header_next) begin
      frame_length_next = frame_length_next | {8'h00, frame.data_byte};
    end

    // Body bytes: data for the CRC lanes, then the big-endian received CRC.
    body_start  = short_header_next ? mfcp_pkg::CNT_W'(3) : mfcp_pkg::CNT_W'(4);
    len_ext     = {1'b0, frame_length_next};
    body_offset = 17'(pos) - 17'(body_start);
    in_body     = in_range && (pos >= body_start) && (frame_length_next >= 16'd2);

    lane_ctrl.accept  = accept;
    lane_ctrl.restart = frame.first_byte;
    lane_ctrl.update  = in_body && (body_offset < len_ext - 17'd2);

    if (in_body && body_offset == len_ext - 17'd2) begin
      received_crc_next[15:8] = frame.data_byte;
    end else if (in_body && body_offset == len_ext - 17'd1) begin
      received_crc_next[7:0] = frame.data_byte;
    end

    byte_count_next = in_range ? pos + mfcp_pkg::CNT_W'(1) : pos;
  end

  mfcp_crc_lanes u_lanes (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (lane_ctrl),
    .data   (frame.data_byte),
    .crc_rx (received_crc_next),
    .match  (lane_match)
  );

  // Frame verdict and field extraction from the state after this byte.
  always_comb begin
    res        = '0;
    res_next   = '0;
    need       = len_ext + (short_header_next ? 17'd5 : 17'd4);
    up_nonzero = 1'b0;

    if (byte_count_next < mfcp_pkg::CNT_W'(5)) begin
      res_next.status = mfcp_pkg::ST_SHORT_FRAME;
    end else if (header_bytes_next[0] != mfcp_pkg::TYPE_CODE) begin
      res_next.status = mfcp_pkg::ST_OTHER_TYPE;
    end else if (17'(byte_count_next) < need) begin
      res_next.status = mfcp_pkg::ST_LENGTH_SHORT;
    end else if (frame_length_next < 16'd2 || !lane_match.found) begin
      res_next.status = mfcp_pkg::ST_CRC_FAIL;
    end else begin
      res_next.status     = mfcp_pkg::ST_OK;
      res_next.subtype    = header_bytes_next[1];
      res_next.net_index  = lane_match.index;
      res_next.network_id = mfcp_pkg::net_init_value(lane_match.index);
      res_next.proto_v5   = version_flag_next;
      if (header_bytes_next[1] != mfcp_pkg::SUB_SHORT) begin
        res_next.present_mask[0] = 1'b1;
      end
      if (header_bytes_next[1] == mfcp_pkg::SUB_LONG) begin
        res_next.dest_address = {header_bytes_next[5], header_bytes_next[6],
                                 header_bytes_next[7], header_bytes_next[8],
                                 header_bytes_next[9], header_bytes_next[10]};
        res_next.source_wan   = {header_bytes_next[11], header_bytes_next[12],
                                 header_bytes_next[13], header_bytes_next[14],
                                 header_bytes_next[15], header_bytes_next[16]};
        res_next.source_id    = {header_bytes_next[24], header_bytes_next[25],
                                 header_bytes_next[26], header_bytes_next[27]};
        res_next.uptime       = {header_bytes_next[18], header_bytes_next[19],
                                 header_bytes_next[20], header_bytes_next[21]};
        res_next.present_mask[2:1] = 2'b11;
      end else if (header_bytes_next[1] == mfcp_pkg::SUB_DEST4) begin
        res_next.dest_address = {16'h0000, header_bytes_next[5], header_bytes_next[6],
                                 header_bytes_next[7], header_bytes_next[8]};
        res_next.source_id    = {header_bytes_next[9], header_bytes_next[10],
                                 header_bytes_next[11], header_bytes_next[12]};
        res_next.present_mask[2] = 1'b1;
        if (frame_length_next == {8'h00, mfcp_pkg::LEN_FULL}) begin
          res_next.timestamp  = {header_bytes_next[14], header_bytes_next[15],
                                 header_bytes_next[16], header_bytes_next[17]};
          res_next.uptime     = {header_bytes_next[22], header_bytes_next[23],
                                 header_bytes_next[24], header_bytes_next[25]};
          res_next.source_wan = {header_bytes_next[30], header_bytes_next[31],
                                 header_bytes_next[32], header_bytes_next[33],
                                 header_bytes_next[34], header_bytes_next[35]};
          res_next.present_mask[3] = 1'b1;
          res_next.present_mask[1] = 1'b1;
        end
      end
      up_nonzero = (res_next.uptime != 32'd0);
      res_next.present_mask[4] = up_nonzero;
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      frame_length <= '0;
      short_header <= 1'b0;
      received_crc <= '0;
      version_flag <= 1'b0;
      for (int i = 0; i < mfcp_pkg::HDR_LEN; i++) begin
        header_bytes[i] <= 8'h00;
      end
    end else if (accept) begin
      byte_count   <= byte_count_next;
      frame_length <= frame_length_next;
      short_header <= short_header_next;
      received_crc <= received_crc_next;
      version_flag <= version_flag_next;
      for (int i = 0; i < mfcp_pkg::HDR_LEN; i++) begin
        header_bytes[i] <= header_bytes_next[i];
      end
    end
  end

  // Result register: loaded by a last byte, emptied when the word is taken.
  mfcp_pkg::result_t res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && frame.last_byte) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && frame.last_byte) begin
      res_q <= res_next | res;
    end
  end

  assign result.valid        = res_valid;
  assign result.status       = res_q.status;
  assign result.subtype      = res_q.subtype;
  assign result.net_index    = res_q.net_index;
  assign result.network_id   = res_q.network_id;
  assign result.proto_v5     = res_q.proto_v5;
  assign result.source_id    = res_q.source_id;
  assign result.source_wan   = res_q.source_wan;
  assign result.dest_address = res_q.dest_address;
  assign result.uptime       = res_q.uptime;
  assign result.timestamp    = res_q.timestamp;
  assign result.present_mask = res_q.present_mask;

endmodule

`default_nettype wire
